// File: rtl/fmtl_pkg.sv
// Shared types, constants and the interpolation function of the field map lookup.
// No dependencies.
`default_nettype none
package fmtl_pkg;
  localparam int MAP_POINTS  = 32768;
  localparam int FIELD_BITS  = 24;
  localparam int ADDR_BITS   = $clog2(MAP_POINTS);
  localparam int COORD_BITS  = 24;
  localparam int DIM_BITS    = 10;
  localparam int FRAC_BITS   = 16;
  localparam int CFG_BITS    = 30;
  localparam int QUEUE_DEPTH = 4;
  localparam int MAG_BITS    = COORD_BITS + 1;
  localparam int PROD_BITS   = MAG_BITS + COORD_BITS;

  typedef enum logic [2:0] {
    REG_X_ORIGIN, REG_Y_ORIGIN, REG_Z_ORIGIN,
    REG_X_INV, REG_Y_INV, REG_Z_INV, REG_GRID_DIMS
  } reg_index_t;

  typedef logic signed [FIELD_BITS-1:0] field_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_origin;
    logic signed [COORD_BITS-1:0] y_origin;
    logic signed [COORD_BITS-1:0] z_origin;
    logic [COORD_BITS-1:0]        x_inv;
    logic [COORD_BITS-1:0]        y_inv;
    logic [COORD_BITS-1:0]        z_inv;
    logic [DIM_BITS-1:0]          xn;
    logic [DIM_BITS-1:0]          yn;
    logic [DIM_BITS-1:0]          zn;
  } cfg_t;

  typedef struct packed {
    logic                 kind;
    logic [ADDR_BITS-1:0] entry_index;
    field_t               bx;
    field_t               by;
    field_t               bz;
    logic [2:0]           neg;
    logic [MAG_BITS-1:0]  dx;
    logic [MAG_BITS-1:0]  dy;
    logic [MAG_BITS-1:0]  dz;
  } work_t;

  typedef struct packed {
    logic                 kind;
    logic                 ok;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [FRAC_BITS-1:0] fz;
    logic [ADDR_BITS-1:0] entry_index;
    field_t               bx;
    field_t               by;
    field_t               bz;
  } ctl_t;

  // lo + (hi - lo) * f / 65536, rounded half up.
  function automatic field_t lerp(field_t lo, field_t hi, logic [FRAC_BITS-1:0] f);
    logic signed [FIELD_BITS:0]             diff;
    logic signed [FIELD_BITS+FRAC_BITS+1:0] prod;
    logic signed [FIELD_BITS+FRAC_BITS+3:0] sum;
    diff = {hi[FIELD_BITS-1], hi} - {lo[FIELD_BITS-1], lo};
    prod = diff * $signed({1'b0, f});
    sum  = ($signed({{(FRAC_BITS+4){lo[FIELD_BITS-1]}}, lo}) <<< FRAC_BITS)
         + $signed({{2{prod[FIELD_BITS+FRAC_BITS+1]}}, prod})
         + $signed((FIELD_BITS+FRAC_BITS+4)'(1 << (FRAC_BITS-1)));
    return sum[FIELD_BITS+FRAC_BITS-1:FRAC_BITS];
  endfunction
endpackage
`default_nettype wire

// File: rtl/fmtl_in_if.sv
// Input channel of the field map lookup: load and query beats.
// Depends on fmtl_pkg.
`default_nettype none
interface fmtl_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  kind;
  logic [fmtl_pkg::ADDR_BITS-1:0]        entry_index;
  logic signed [fmtl_pkg::FIELD_BITS-1:0] load_bx;
  logic signed [fmtl_pkg::FIELD_BITS-1:0] load_by;
  logic signed [fmtl_pkg::FIELD_BITS-1:0] load_bz;
  logic signed [fmtl_pkg::COORD_BITS-1:0] pos_x;
  logic signed [fmtl_pkg::COORD_BITS-1:0] pos_y;
  logic signed [fmtl_pkg::COORD_BITS-1:0] pos_z;
  modport source (output valid, kind, entry_index, load_bx, load_by, load_bz,
                  pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, kind, entry_index, load_bx, load_by, load_bz,
                pos_x, pos_y, pos_z, output ready);
endinterface
`default_nettype wire

// File: rtl/fmtl_out_if.sv
// Result channel of the field map lookup.
// Depends on fmtl_pkg.
`default_nettype none
interface fmtl_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [fmtl_pkg::FIELD_BITS-1:0] field_x;
  logic signed [fmtl_pkg::FIELD_BITS-1:0] field_y;
  logic signed [fmtl_pkg::FIELD_BITS-1:0] field_z;
  logic                                  out_of_range;
  modport source (output valid, field_x, field_y, field_z, out_of_range, input ready);
  modport sink (input valid, field_x, field_y, field_z, out_of_range, output ready);
endinterface
`default_nettype wire

// File: rtl/fmtl_front.sv
// Front end: mirrors query x and y and subtracts the grid origin per axis.
// Depends on fmtl_pkg and fmtl_in_if.
`default_nettype none
module fmtl_front (
  fmtl_in_if.sink        req,
  input  fmtl_pkg::cfg_t cfg,
  output fmtl_pkg::work_t item
);
  localparam int W = fmtl_pkg::COORD_BITS;
  logic signed [W+1:0] ax, ay, az, ddx, ddy, ddz;

  always_comb begin
    ax  = req.pos_x[W-1] ? -$signed({{2{req.pos_x[W-1]}}, req.pos_x})
                         : $signed({{2{req.pos_x[W-1]}}, req.pos_x});
    ay  = req.pos_y[W-1] ? -$signed({{2{req.pos_y[W-1]}}, req.pos_y})
                         : $signed({{2{req.pos_y[W-1]}}, req.pos_y});
    az  = $signed({{2{req.pos_z[W-1]}}, req.pos_z});
    ddx = ax - $signed({{2{cfg.x_origin[W-1]}}, cfg.x_origin});
    ddy = ay - $signed({{2{cfg.y_origin[W-1]}}, cfg.y_origin});
    ddz = az - $signed({{2{cfg.z_origin[W-1]}}, cfg.z_origin});
    item.kind        = req.kind;
    item.entry_index = req.entry_index;
    item.bx          = req.load_bx;
    item.by          = req.load_by;
    item.bz          = req.load_bz;
    item.neg         = {ddz[W+1], ddy[W+1], ddx[W+1]};
    item.dx          = ddx[W:0];
    item.dy          = ddy[W:0];
    item.dz          = ddz[W:0];
  end
endmodule
`default_nettype wire

// File: rtl/fmtl_queue.sv
// Short queue between the front end and the lookup pipeline.
// Depends on fmtl_pkg.
`default_nettype none
module fmtl_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fmtl_pkg::work_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output fmtl_pkg::work_t head
);
  localparam int PW = $clog2(fmtl_pkg::QUEUE_DEPTH);
  fmtl_pkg::work_t slots [fmtl_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign full      = (count == (PW+1)'(fmtl_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !not_empty |-> !pop)
    else $error("queue read while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + (PW+1)'(1))
    else $error("queue count did not advance");
endmodule
`default_nettype wire

// File: rtl/fmtl_back.sv
// Lookup pipeline: cell split, corner addressing, eight corner memories and lerps.
// Depends on fmtl_pkg and fmtl_out_if.
`default_nettype none
module fmtl_back (
  input  logic            clk,
  input  logic            rst,
  input  fmtl_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  fmtl_pkg::work_t q_head,
  output logic            q_pop,
  fmtl_out_if.source      rsp
);
  localparam int AB = fmtl_pkg::ADDR_BITS;
  localparam int FB = fmtl_pkg::FIELD_BITS;
  localparam int DB = fmtl_pkg::DIM_BITS;
  localparam int PB = fmtl_pkg::PROD_BITS;
  localparam int CB = PB - 24;
  localparam int BB = 2 * DB + DB + 2;

  logic en;
  logic [8:1] v;
  fmtl_pkg::ctl_t c2, c3, c4, c5, c6, c7, c8;
  fmtl_pkg::ctl_t c5_next;

  fmtl_pkg::work_t s1;
  logic [PB-1:0] hx, hy, hz;
  logic [CB-1:0] cx, cy, cz;
  logic okx, oky, okz;
  logic [DB-1:0] iy2, iz2, iz3;
  logic [2*DB-1:0] p1, dxs;
  logic [2*DB:0] a3;
  logic [BB-1:0] base4;
  logic [BB:0] top5;
  logic [AB-1:0] addr [8];
  logic [3*FB-1:0] rd [8];
  fmtl_pkg::field_t lx [3][4];
  fmtl_pkg::field_t ly [3][2];
  fmtl_pkg::field_t res [3];

  assign en    = !rsp.valid || rsp.ready;
  assign q_pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[7:1], q_valid};
    end
  end

  assign cx  = hx[PB-1:24];
  assign cy  = hy[PB-1:24];
  assign cz  = hz[PB-1:24];
  assign okx = !s1.neg[0] && ({1'b0, cx} + (CB+1)'(1)) < (CB+1)'(cfg.xn);
  assign oky = !s1.neg[1] && ({1'b0, cy} + (CB+1)'(1)) < (CB+1)'(cfg.yn);
  assign okz = !s1.neg[2] && ({1'b0, cz} + (CB+1)'(1)) < (CB+1)'(cfg.zn);
  assign top5 = {1'b0, base4} + (BB+1)'(dxs) + (BB+1)'(cfg.zn) + (BB+1)'(1);

  always_comb begin
    c5_next    = c4;
    c5_next.ok = c4.ok && (top5 < (BB+1)'(fmtl_pkg::MAP_POINTS));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= q_head;
      hx <= q_head.dx * cfg.x_inv;
      hy <= q_head.dy * cfg.y_inv;
      hz <= q_head.dz * cfg.z_inv;

      c2.kind <= s1.kind;
      c2.ok <= okx && oky && okz;
      c2.fx <= hx[23:8];
      c2.fy <= hy[23:8];
      c2.fz <= hz[23:8];
      c2.entry_index <= s1.entry_index;
      c2.bx <= s1.bx;
      c2.by <= s1.by;
      c2.bz <= s1.bz;
      iy2 <= cy[DB-1:0];
      iz2 <= cz[DB-1:0];
      p1  <= cx[DB-1:0] * cfg.yn;
      dxs <= cfg.yn * cfg.zn;

      c3  <= c2;
      a3  <= {1'b0, p1} + (2*DB+1)'(iy2);
      iz3 <= iz2;

      c4    <= c3;
      base4 <= BB'(a3 * cfg.zn) + BB'(iz3);

      c5 <= c5_next;
      for (int k = 0; k < 8; k++) begin
        addr[k] <= AB'(base4 + (k[2] ? BB'(dxs) : BB'(0))
                   + (k[1] ? BB'(cfg.zn) : BB'(0)) + BB'(k[0]));
      end

      c6 <= c5;
      c7 <= c6;
      for (int c = 0; c < 3; c++) begin
        for (int j = 0; j < 4; j++) begin
          lx[c][j] <= fmtl_pkg::lerp(rd[j][(2-c)*FB +: FB], rd[j+4][(2-c)*FB +: FB], c6.fx);
        end
      end
      c8 <= c7;
      for (int c = 0; c < 3; c++) begin
        ly[c][0] <= fmtl_pkg::lerp(lx[c][0], lx[c][2], c7.fy);
        ly[c][1] <= fmtl_pkg::lerp(lx[c][1], lx[c][3], c7.fy);
      end
    end
  end

  for (genvar k = 0; k < 8; k++) begin : g_corner
    logic [3*FB-1:0] mem [fmtl_pkg::MAP_POINTS];
    always_ff @(posedge clk) begin
      if (en && v[5] && !c5.kind) begin
        mem[c5.entry_index] <= {c5.bx, c5.by, c5.bz};
      end
      if (en) begin
        rd[k] <= mem[addr[k]];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      res[c] = fmtl_pkg::lerp(ly[c][0], ly[c][1], c8.fz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= v[8] && c8.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.field_x      <= c8.ok ? res[0] : '0;
      rsp.field_y      <= c8.ok ? res[1] : '0;
      rsp.field_z      <= c8.ok ? res[2] : '0;
      rsp.out_of_range <= !c8.ok;
    end
  end

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.out_of_range |->
      rsp.field_x == '0 && rsp.field_y == '0 && rsp.field_z == '0)
    else $error("out-of-range result carries a field value");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |-> !q_pop ##1 $stable(v))
    else $error("pipeline moved while the result beat was stalled");
  a_reset_clear: assert property (@(posedge clk) rst |=> !rsp.valid && v == '0)
    else $error("pipeline not empty after reset");
endmodule
`default_nettype wire

// File: rtl/field_map_trilinear_lookup.sv
// Trilinear field map lookup: one beat accepted per cycle while the queue is not full,
// loads and queries in any mix. Query results leave in order through the queue and pipeline.
// Eight replicated corner memories read in parallel give one beat per cycle when not stalled.
// Loads write all replicas in pipeline order, so a query sees every earlier load.
// Reset clears configuration to its defaults and empties the queue and pipeline;
// the field memories are not cleared.
`default_nettype none
module field_map_trilinear_lookup (
  input  logic                           clk,
  input  logic                           rst,
  fmtl_in_if.sink                        req,
  fmtl_out_if.source                     rsp,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [fmtl_pkg::CFG_BITS-1:0]  cfg_data
);
  localparam int W  = fmtl_pkg::COORD_BITS;
  localparam int DB = fmtl_pkg::DIM_BITS;

  fmtl_pkg::cfg_t  cfg;
  fmtl_pkg::work_t item, head;
  logic full, not_empty, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_origin <= '0;
      cfg.y_origin <= '0;
      cfg.z_origin <= '0;
      cfg.x_inv    <= W'(65536);
      cfg.y_inv    <= W'(65536);
      cfg.z_inv    <= W'(65536);
      cfg.xn       <= DB'(1);
      cfg.yn       <= DB'(33);
      cfg.zn       <= DB'(33);
    end else if (cfg_we) begin
      unique case (fmtl_pkg::reg_index_t'(cfg_index))
        fmtl_pkg::REG_X_ORIGIN:  cfg.x_origin <= cfg_data[W-1:0];
        fmtl_pkg::REG_Y_ORIGIN:  cfg.y_origin <= cfg_data[W-1:0];
        fmtl_pkg::REG_Z_ORIGIN:  cfg.z_origin <= cfg_data[W-1:0];
        fmtl_pkg::REG_X_INV:     cfg.x_inv    <= cfg_data[W-1:0];
        fmtl_pkg::REG_Y_INV:     cfg.y_inv    <= cfg_data[W-1:0];
        fmtl_pkg::REG_Z_INV:     cfg.z_inv    <= cfg_data[W-1:0];
        fmtl_pkg::REG_GRID_DIMS: begin
          cfg.xn <= cfg_data[3*DB-1:2*DB];
          cfg.yn <= cfg_data[2*DB-1:DB];
          cfg.zn <= cfg_data[DB-1:0];
        end
        default: ;
      endcase
    end
  end

  assign req.ready = !full;

  fmtl_front u_front (
    .req  (req),
    .cfg  (cfg),
    .item (item)
  );

  fmtl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (req.valid && req.ready),
    .push_data (item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  fmtl_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (not_empty),
    .q_head  (head),
    .q_pop   (pop),
    .rsp     (rsp)
  );
endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench of field_map_trilinear_lookup: random and directed loads and queries
// checked against an in-order predictor of the grid store and interpolation.
// Depends on fmtl_pkg, fmtl_in_if, fmtl_out_if and the block itself.
module tb;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PRELOAD_POINTS = 128;
  localparam logic LOAD  = 1'b0;
  localparam logic QUERY = 1'b1;

  typedef struct {
    logic        kind;
    logic [14:0] idx;
    logic [23:0] bx, by, bz;
    logic [23:0] px, py, pz;
  } beat_t;

  typedef struct {
    logic [23:0] fx, fy, fz;
    logic        oor;
  } field_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [fmtl_pkg::CFG_BITS-1:0] cfg_data = '0;

  fmtl_in_if  req();
  fmtl_out_if rsp();

  field_map_trilinear_lookup uut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  beat_t pending_beats[$];
  field_result_t expected_fields[$];
  longint bx_mem[fmtl_pkg::MAP_POINTS], by_mem[fmtl_pkg::MAP_POINTS];
  longint bz_mem[fmtl_pkg::MAP_POINTS];
  longint org[3];
  longint inv[3];
  longint dims[3];
  int mismatches = 0, checked = 0, queries_sent = 0, loads_sent = 0;
  int idle_cycles = 0, in_gap = 0, rsp_gap = 0;
  bit in_fire = 0, no_idle = 0;

  initial forever #5 clk = ~clk;

  initial begin
    req.valid = 1'b0; req.kind = 1'b0; req.entry_index = '0;
    req.load_bx = '0; req.load_by = '0; req.load_bz = '0;
    req.pos_x = '0; req.pos_y = '0; req.pos_z = '0;
    rsp.ready = 1'b0;
  end

  function automatic int pick_gap();
    if (no_idle || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint field_lerp(longint lo, longint hi, longint f);
    return (lo * (65536 - f) + hi * f + 32768) >>> 16;
  endfunction

  function automatic longint sat24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint cell_blend(ref longint s[fmtl_pkg::MAP_POINTS],
                                        input longint base, longint sx, longint sy,
                                        longint f[3]);
    longint c00, c10, c01, c11;
    c00 = field_lerp(s[base], s[base + sx], f[0]);
    c10 = field_lerp(s[base + sy], s[base + sx + sy], f[0]);
    c01 = field_lerp(s[base + 1], s[base + sx + 1], f[0]);
    c11 = field_lerp(s[base + sy + 1], s[base + sx + sy + 1], f[0]);
    return field_lerp(field_lerp(c00, c10, f[1]), field_lerp(c01, c11, f[1]), f[2]);
  endfunction

  function automatic void apply_beat(beat_t b);
    longint p[3], cidx[3], f[3], d, h, base, top;
    field_result_t r;
    bit ok;
    if (b.kind == LOAD) begin
      bx_mem[b.idx] = longint'($signed(b.bx));
      by_mem[b.idx] = longint'($signed(b.by));
      bz_mem[b.idx] = longint'($signed(b.bz));
      return;
    end
    p[0] = longint'($signed(b.px));
    p[1] = longint'($signed(b.py));
    p[2] = longint'($signed(b.pz));
    if (p[0] < 0) p[0] = -p[0];
    if (p[1] < 0) p[1] = -p[1];
    ok = 1;
    for (int a = 0; a < 3; a++) begin
      d = p[a] - org[a];
      if (d < 0) begin
        ok = 0;
      end else begin
        h = d * inv[a];
        cidx[a] = h >>> 24;
        f[a] = (h >>> 8) & 16'hFFFF;
        if (cidx[a] + 1 >= dims[a]) ok = 0;
      end
    end
    r = '{24'd0, 24'd0, 24'd0, 1'b1};
    if (ok) begin
      base = (cidx[0] * dims[1] + cidx[1]) * dims[2] + cidx[2];
      top = base + dims[1] * dims[2] + dims[2] + 1;
      if (top < fmtl_pkg::MAP_POINTS) begin
        r.fx = 24'(sat24(cell_blend(bx_mem, base, dims[1] * dims[2], dims[2], f)));
        r.fy = 24'(sat24(cell_blend(by_mem, base, dims[1] * dims[2], dims[2], f)));
        r.fz = 24'(sat24(cell_blend(bz_mem, base, dims[1] * dims[2], dims[2], f)));
        r.oor = 1'b0;
      end
    end
    expected_fields.push_back(r);
  endfunction

  always @(posedge clk) begin
    in_fire <= req.valid && req.ready;
    if (!rst && req.valid && req.ready) begin
      apply_beat('{req.kind, req.entry_index, req.load_bx, req.load_by, req.load_bz,
                   req.pos_x, req.pos_y, req.pos_z});
    end
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_fields.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat at %0t", $realtime);
      end else begin
        field_result_t e;
        e = expected_fields.pop_front();
        checked++;
        if (rsp.field_x !== e.fx || rsp.field_y !== e.fy || rsp.field_z !== e.fz ||
            rsp.out_of_range !== e.oor) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at %0t: expected %0d %0d %0d oor %0b, got %0d %0d %0d oor %0b",
                     $realtime, $signed(e.fx), $signed(e.fy), $signed(e.fz), e.oor,
                     rsp.field_x, rsp.field_y, rsp.field_z, rsp.out_of_range);
        end
      end
    end
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", expected_fields.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (rsp_gap > 0) begin
        rsp_gap = rsp_gap - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        rsp_gap = pick_gap();
      end
      if (in_fire || !req.valid) begin
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
          req.valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          beat_t b;
          b = pending_beats.pop_front();
          req.valid <= 1'b1;
          req.kind <= b.kind; req.entry_index <= b.idx;
          req.load_bx <= b.bx; req.load_by <= b.by; req.load_bz <= b.bz;
          req.pos_x <= b.px; req.pos_y <= b.py; req.pos_z <= b.pz;
          in_gap = pick_gap();
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  task automatic write_reg(fmtl_pkg::reg_index_t r, longint v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= fmtl_pkg::CFG_BITS'(v);
    case (r)
      fmtl_pkg::REG_X_ORIGIN:  org[0] = longint'($signed(24'(v)));
      fmtl_pkg::REG_Y_ORIGIN:  org[1] = longint'($signed(24'(v)));
      fmtl_pkg::REG_Z_ORIGIN:  org[2] = longint'($signed(24'(v)));
      fmtl_pkg::REG_X_INV:     inv[0] = v & 24'hFFFFFF;
      fmtl_pkg::REG_Y_INV:     inv[1] = v & 24'hFFFFFF;
      fmtl_pkg::REG_Z_INV:     inv[2] = v & 24'hFFFFFF;
      fmtl_pkg::REG_GRID_DIMS: begin
        dims[0] = (v >> 20) & 10'h3FF;
        dims[1] = (v >> 10) & 10'h3FF;
        dims[2] = v & 10'h3FF;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_grid(longint ox, longint oy, longint oz, longint ix, longint iy,
                          longint iz, longint nx, longint ny, longint nz);
    write_reg(fmtl_pkg::REG_X_ORIGIN, ox);
    write_reg(fmtl_pkg::REG_Y_ORIGIN, oy);
    write_reg(fmtl_pkg::REG_Z_ORIGIN, oz);
    write_reg(fmtl_pkg::REG_X_INV, ix);
    write_reg(fmtl_pkg::REG_Y_INV, iy);
    write_reg(fmtl_pkg::REG_Z_INV, iz);
    write_reg(fmtl_pkg::REG_GRID_DIMS, (nx << 20) | (ny << 10) | nz);
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || expected_fields.size() != 0 || req.valid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void push_load(longint i, longint x, longint y, longint z);
    pending_beats.push_back('{LOAD, 15'(i), 24'(x), 24'(y), 24'(z), 24'd0, 24'd0, 24'd0});
    loads_sent++;
  endfunction

  function automatic void push_query(longint x, longint y, longint z);
    pending_beats.push_back('{QUERY, 15'($urandom), 24'($urandom), 24'($urandom),
                              24'($urandom), 24'(x), 24'(y), 24'(z)});
    queries_sent++;
  endfunction

  function automatic longint near_grid(int a);
    longint span, d, p;
    span = (inv[a] == 0) ? 4096 : ((dims[a] + 1) << 24) / inv[a];
    if (span > 4000000) span = 4000000;
    d = $urandom_range(0, int'(span));
    if ($urandom_range(0, 15) == 0) d = -longint'($urandom_range(1, 2048));
    p = sat24(org[a] + d);
    if (a < 2 && $urandom_range(0, 1) == 1 && p > -8388608) p = -p;
    return p;
  endfunction

  task automatic random_traffic(int n);
    longint span;
    span = dims[0] * dims[1] * dims[2];
    if (span < 1 || span > fmtl_pkg::MAP_POINTS) span = fmtl_pkg::MAP_POINTS;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0, 1: push_load($urandom_range(0, int'(span) - 1), $urandom, $urandom, $urandom);
        2:    push_query(longint'($signed(24'($urandom))), longint'($signed(24'($urandom))),
                         longint'($signed(24'($urandom))));
        default: push_query(near_grid(0), near_grid(1), near_grid(2));
      endcase
    end
  endtask

  initial begin
    org = '{0, 0, 0};
    inv = '{65536, 65536, 65536};
    dims = '{1, 33, 33};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default grid is one point deep in x, so every query lands outside it.
    push_query(0, 0, 0);
    push_query(-8388608, 8388607, -8388608);
    push_load(0, -8388608, 8388607, 0);
    push_load(32767, 8388607, -8388608, -1);
    for (int i = 0; i < PRELOAD_POINTS; i++) begin
      if (i % 97 == 0) push_load(i, -8388608 + $urandom_range(0, 3), 8388607, $urandom);
      else push_load(i, $urandom, $urandom, $urandom);
    end
    wait_idle();

    set_grid(0, 0, 0, 65536, 65536, 65536, 4, 5, 6);
    push_query(0, 0, 0);
    push_query(256, 512, 768);
    push_query(383, -383, 383);
    push_query(-767, 700, 1279);
    push_query(255, 255, 255);
    push_query(0, 0, -1);
    push_query(768, 0, 0);
    push_query(0, 1024, 0);
    push_query(0, 0, 1280);
    push_query(8388607, 0, 0);
    push_load(57, 8388607, -8388608, 8388607);
    push_load(58, -8388608, 8388607, -8388608);
    push_query(300, 100, 250);
    push_query(100, 600, 1100);
    wait_idle();

    set_grid(-8388608, 8388607, -8388608, 16777215, 0, 16777215, 1023, 1023, 1023);
    push_query(-8388608, 8388607, -8388608);
    push_query(0, 8388607, 8388607);
    random_traffic(20);
    wait_idle();

    set_grid(8388607, -8388608, 0, 0, 16777215, 0, 0, 0, 0);
    random_traffic(10);
    wait_idle();

    set_grid(0, 0, 0, 0, 0, 1, 2, 2, 2);
    push_query(100, 8388607, 8388607);
    random_traffic(10);
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      no_idle = (ph % 3 == 1);
      set_grid($urandom_range(0, 4096) - 2048, $urandom_range(0, 4096) - 2048,
               $urandom_range(0, 4096) - 2048, $urandom_range(256, 1 << 20),
               $urandom_range(256, 1 << 20), $urandom_range(256, 1 << 20),
               $urandom_range(2, 5), $urandom_range(2, 5), $urandom_range(2, 5));
      random_traffic(30);
      wait_idle();
    end
    no_idle = 0;
    wait_idle();

    $display("Sent %0d loads and %0d queries over 12 grid settings; %0d results checked.",
             loads_sent, queries_sent, checked);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
